FILE: rtl/triangle_centroid_height_search_assert.svh
// =============================================================================
// Triangle centroid height search: assertion macros
// Shared concurrent assertion forms used by the block's modules.
// =============================================================================
`ifndef TRIANGLE_CENTROID_HEIGHT_SEARCH_ASSERT_SVH
`define TRIANGLE_CENTROID_HEIGHT_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcs_pkg.sv
`timescale 1ns / 1ps
// =============================================================================
// Triangle centroid height search package
// Shared constants, types and helper functions.
// =============================================================================
package tcs_pkg;

    // Store geometry.
    localparam int VERTEX_DEPTH   = 4096;
    localparam int TRIANGLE_DEPTH = 8192;
    localparam int VTX_AW         = $clog2(VERTEX_DEPTH);
    localparam int TRI_AW         = $clog2(TRIANGLE_DEPTH);

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 13;
    localparam int COORD_W  = 24;
    localparam int CORNER_W = 12;
    localparam int COUNT_W  = 14;
    localparam int VTX_W    = 3 * COORD_W;
    localparam int TRI_W    = 3 * CORNER_W;

    // Input tdata layout, lowest field first.
    localparam int SLOT_LSB   = 0;
    localparam int X_LSB      = SLOT_LSB + SLOT_W;
    localparam int H_LSB      = X_LSB + COORD_W;
    localparam int Z_LSB      = H_LSB + COORD_W;
    localparam int A_LSB      = Z_LSB + COORD_W;
    localparam int B_LSB      = A_LSB + CORNER_W;
    localparam int C_LSB      = B_LSB + CORNER_W;
    localparam int S_TDATA_W  = ((C_LSB + CORNER_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((COORD_W + 7) / 8) * 8;

    // Arithmetic widths. A sum of three coordinates needs two extra bits, its
    // magnitude stays below 2**25.
    localparam int SUM_W       = COORD_W + 2;
    localparam int MAG_W       = COORD_W + 1;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 25;
    localparam int PROD_W      = MAG_W + RECIP_W;
    // ceil(2**26 / 3): exact floor division by three for magnitudes below 2**25.
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((2**RECIP_SHIFT + 2) / 3);

    // Scan pipeline: triangle read, vertex read, sum, magnitude, multiply,
    // sign, distance.
    localparam int PIPE_STAGES = 7;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TRIANGLE_COUNT = 1'b0;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_VERTEX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              vtx_wr;
        logic              tri_wr;
        logic              query_start;
        logic              issue;
        logic [TRI_AW-1:0] issue_addr;
        logic              result_load;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } status_t;

    function automatic logic signed [SUM_W-1:0] sext_sum(input logic [COORD_W-1:0] v);
        return {{(SUM_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic [MAG_W-1:0] sum_mag(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] m;
        m = s[SUM_W-1] ? -s : s;
        return m[MAG_W-1:0];
    endfunction

endpackage

FILE: rtl/tcs_ram.sv
`timescale 1ns / 1ps
// =============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// =============================================================================
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tcs_datapath.sv
`timescale 1ns / 1ps
// =============================================================================
// Triangle centroid height search datapath
// Stores, scan pipeline, best-candidate tracking and output register.
// =============================================================================
`include "triangle_centroid_height_search_assert.svh"

module tcs_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tcs_pkg::cmd_t                  cmd,
    output tcs_pkg::status_t               status,
    input  logic [tcs_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcs_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);

    localparam int CW = tcs_pkg::COORD_W;

    logic [tcs_pkg::SLOT_W-1:0]   slot;
    logic [CW-1:0]                in_x, in_h, in_z;
    logic [tcs_pkg::TRI_W-1:0]    tri_wdata, tri_rdata;
    logic [tcs_pkg::VTX_W-1:0]    vtx_wdata, va, vb, vc;
    logic                         vtx_we, tri_we;
    logic [tcs_pkg::VTX_AW-1:0]   addr_a, addr_b, addr_c;

    assign slot      = s_tdata[tcs_pkg::SLOT_LSB +: tcs_pkg::SLOT_W];
    assign in_x      = s_tdata[tcs_pkg::X_LSB +: CW];
    assign in_h      = s_tdata[tcs_pkg::H_LSB +: CW];
    assign in_z      = s_tdata[tcs_pkg::Z_LSB +: CW];
    assign vtx_wdata = {in_z, in_h, in_x};
    assign tri_wdata = s_tdata[tcs_pkg::A_LSB +: tcs_pkg::TRI_W];
    assign vtx_we    = cmd.vtx_wr && (int'(slot) < tcs_pkg::VERTEX_DEPTH);
    assign tri_we    = cmd.tri_wr && (int'(slot) < tcs_pkg::TRIANGLE_DEPTH);

    // Corner indices span the whole vertex store address.
    assign addr_a = tri_rdata[0 +: tcs_pkg::VTX_AW];
    assign addr_b = tri_rdata[tcs_pkg::CORNER_W +: tcs_pkg::VTX_AW];
    assign addr_c = tri_rdata[2 * tcs_pkg::CORNER_W +: tcs_pkg::VTX_AW];

    tcs_ram #(.WIDTH(tcs_pkg::TRI_W), .DEPTH(tcs_pkg::TRIANGLE_DEPTH)) u_tri_ram (
        .aclk    (aclk),
        .wr_en   (tri_we),
        .wr_addr (slot[tcs_pkg::TRI_AW-1:0]),
        .wr_data (tri_wdata),
        .rd_addr (cmd.issue_addr),
        .rd_data (tri_rdata)
    );

    // Three copies of the vertex store give one corner read each per cycle.
    tcs_ram #(.WIDTH(tcs_pkg::VTX_W), .DEPTH(tcs_pkg::VERTEX_DEPTH)) u_vtx_ram_a (
        .aclk    (aclk),
        .wr_en   (vtx_we),
        .wr_addr (slot[tcs_pkg::VTX_AW-1:0]),
        .wr_data (vtx_wdata),
        .rd_addr (addr_a),
        .rd_data (va)
    );

    tcs_ram #(.WIDTH(tcs_pkg::VTX_W), .DEPTH(tcs_pkg::VERTEX_DEPTH)) u_vtx_ram_b (
        .aclk    (aclk),
        .wr_en   (vtx_we),
        .wr_addr (slot[tcs_pkg::VTX_AW-1:0]),
        .wr_data (vtx_wdata),
        .rd_addr (addr_b),
        .rd_data (vb)
    );

    tcs_ram #(.WIDTH(tcs_pkg::VTX_W), .DEPTH(tcs_pkg::VERTEX_DEPTH)) u_vtx_ram_c (
        .aclk    (aclk),
        .wr_en   (vtx_we),
        .wr_addr (slot[tcs_pkg::VTX_AW-1:0]),
        .wr_data (vtx_wdata),
        .rd_addr (addr_c),
        .rd_data (vc)
    );

    // Pipeline valid bits and query point.
    logic [tcs_pkg::PIPE_STAGES-1:0] vld_reg, vld_next;
    logic [CW-1:0]                   qx_reg, qz_reg;

    // Sum stage.
    logic signed [tcs_pkg::SUM_W-1:0] sum_x_reg, sum_h_reg, sum_z_reg;
    logic signed [tcs_pkg::SUM_W-1:0] sum_x_next, sum_h_next, sum_z_next;
    // Magnitude stage.
    logic [tcs_pkg::MAG_W-1:0]        mag_x_reg, mag_h_reg, mag_z_reg;
    logic [2:0]                       neg_m_reg, neg_q_reg;
    // Quotient stage.
    logic [tcs_pkg::PROD_W-1:0]       prod_x, prod_h, prod_z;
    logic [CW-1:0]                    quo_x_reg, quo_h_reg, quo_z_reg;
    // Signed centroid stage.
    logic [CW-1:0]                    cen_x_reg, cen_h_reg, cen_z_reg;
    // Distance stage.
    logic signed [CW:0]               diff_x, diff_z, adiff_x, adiff_z;
    logic [CW-1:0]                    dist_x_reg, dist_z_reg, hgt_reg;
    // Best candidate.
    logic [CW-1:0]                    best_x_reg, best_z_reg, height_reg;
    logic                             found_reg, take;
    // Output register.
    logic                             m_valid_reg;
    logic [CW-1:0]                    m_height_reg;
    logic                             m_found_reg;

    assign vld_next = {vld_reg[tcs_pkg::PIPE_STAGES-2:0], cmd.issue};

    always_comb begin
        sum_x_next = tcs_pkg::sext_sum(va[0 +: CW]) + tcs_pkg::sext_sum(vb[0 +: CW])
                   + tcs_pkg::sext_sum(vc[0 +: CW]);
        sum_h_next = tcs_pkg::sext_sum(va[CW +: CW]) + tcs_pkg::sext_sum(vb[CW +: CW])
                   + tcs_pkg::sext_sum(vc[CW +: CW]);
        sum_z_next = tcs_pkg::sext_sum(va[2*CW +: CW]) + tcs_pkg::sext_sum(vb[2*CW +: CW])
                   + tcs_pkg::sext_sum(vc[2*CW +: CW]);
    end

    assign prod_x = tcs_pkg::PROD_W'(mag_x_reg) * tcs_pkg::PROD_W'(tcs_pkg::RECIP3);
    assign prod_h = tcs_pkg::PROD_W'(mag_h_reg) * tcs_pkg::PROD_W'(tcs_pkg::RECIP3);
    assign prod_z = tcs_pkg::PROD_W'(mag_z_reg) * tcs_pkg::PROD_W'(tcs_pkg::RECIP3);

    assign diff_x  = $signed({cen_x_reg[CW-1], cen_x_reg}) - $signed({qx_reg[CW-1], qx_reg});
    assign diff_z  = $signed({cen_z_reg[CW-1], cen_z_reg}) - $signed({qz_reg[CW-1], qz_reg});
    assign adiff_x = diff_x[CW] ? -diff_x : diff_x;
    assign adiff_z = diff_z[CW] ? -diff_z : diff_z;

    // The first triangle of a scan is always taken; later ones must beat the
    // held distances on both axes.
    assign take = vld_reg[6] &&
                  (!found_reg || ((dist_x_reg < best_x_reg) && (dist_z_reg < best_z_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            found_reg   <= 1'b0;
            height_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            if (cmd.query_start) begin
                found_reg  <= 1'b0;
                height_reg <= '0;
            end else if (take) begin
                found_reg  <= 1'b1;
                height_reg <= hgt_reg;
            end
            if (cmd.result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.query_start) begin
            qx_reg <= in_x;
            qz_reg <= in_z;
        end
        sum_x_reg <= sum_x_next;
        sum_h_reg <= sum_h_next;
        sum_z_reg <= sum_z_next;

        mag_x_reg <= tcs_pkg::sum_mag(sum_x_reg);
        mag_h_reg <= tcs_pkg::sum_mag(sum_h_reg);
        mag_z_reg <= tcs_pkg::sum_mag(sum_z_reg);
        neg_m_reg <= {sum_z_reg[tcs_pkg::SUM_W-1], sum_h_reg[tcs_pkg::SUM_W-1],
                      sum_x_reg[tcs_pkg::SUM_W-1]};

        quo_x_reg <= prod_x[tcs_pkg::RECIP_SHIFT +: CW];
        quo_h_reg <= prod_h[tcs_pkg::RECIP_SHIFT +: CW];
        quo_z_reg <= prod_z[tcs_pkg::RECIP_SHIFT +: CW];
        neg_q_reg <= neg_m_reg;

        // Restoring the sign after the magnitude divide rounds toward zero.
        cen_x_reg <= neg_q_reg[0] ? -quo_x_reg : quo_x_reg;
        cen_h_reg <= neg_q_reg[1] ? -quo_h_reg : quo_h_reg;
        cen_z_reg <= neg_q_reg[2] ? -quo_z_reg : quo_z_reg;

        dist_x_reg <= adiff_x[CW-1:0];
        dist_z_reg <= adiff_z[CW-1:0];
        hgt_reg    <= cen_h_reg;

        if (take) begin
            best_x_reg <= dist_x_reg;
            best_z_reg <= dist_z_reg;
        end

        if (cmd.result_load) begin
            m_height_reg <= height_reg;
            m_found_reg  <= found_reg;
        end
    end

    assign status.pipe_busy = |vld_reg;
    assign status.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tcs_pkg::M_TDATA_W'(m_height_reg);
    assign m_tuser  = m_found_reg;

    `TCS_ASSERT_IMPLY(a_no_find_zero_height, aclk, aresetn, !found_reg, height_reg == '0, "height held without an accepted triangle")

endmodule

FILE: rtl/tcs_control.sv
`timescale 1ns / 1ps
// =============================================================================
// Triangle centroid height search controller
// Accepts items, sequences the triangle scan and hands off the result.
// =============================================================================
`include "triangle_centroid_height_search_assert.svh"

module tcs_control (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tcs_pkg::KIND_W-1:0]    kind,
    input  logic [tcs_pkg::COUNT_W-1:0]   triangle_count,
    output tcs_pkg::cmd_t                 cmd,
    input  tcs_pkg::status_t              status
);

    tcs_pkg::state_t                state_reg, state_next;
    logic [tcs_pkg::COUNT_W-1:0]    idx_reg, idx_next;
    logic [tcs_pkg::COUNT_W-1:0]    count_eff;
    logic                           accept;

    // Counts above the store depth scan the whole store.
    assign count_eff = (int'(triangle_count) > tcs_pkg::TRIANGLE_DEPTH)
                     ? tcs_pkg::COUNT_W'(tcs_pkg::TRIANGLE_DEPTH) : triangle_count;

    assign s_tready = (state_reg == tcs_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcs_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.issue_addr = idx_reg[tcs_pkg::TRI_AW-1:0];
        case (state_reg)
            tcs_pkg::ST_IDLE: begin
                if (accept) begin
                    case (kind)
                        tcs_pkg::KIND_VERTEX:   cmd.vtx_wr = 1'b1;
                        tcs_pkg::KIND_TRIANGLE: cmd.tri_wr = 1'b1;
                        tcs_pkg::KIND_QUERY: begin
                            cmd.query_start = 1'b1;
                            idx_next        = '0;
                            state_next      = (count_eff == '0) ? tcs_pkg::ST_FINISH
                                                                : tcs_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            tcs_pkg::ST_SCAN: begin
                cmd.issue = 1'b1;
                if (idx_reg == count_eff - 1'b1) begin
                    state_next = tcs_pkg::ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tcs_pkg::ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = tcs_pkg::ST_FINISH;
                end
            end
            tcs_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = tcs_pkg::ST_IDLE;
                end
            end
            default: state_next = tcs_pkg::ST_IDLE;
        endcase
    end

    `TCS_ASSERT_IMPLY(a_idle_pipe_empty, aclk, aresetn, state_reg == tcs_pkg::ST_IDLE, !status.pipe_busy, "scan pipeline busy while idle")
    `TCS_ASSERT_IMPLY(a_issue_in_range, aclk, aresetn, cmd.issue, idx_reg < count_eff, "triangle read beyond scan count")
    `TCS_ASSERT_NEXT(a_query_scans, aclk, aresetn, cmd.query_start && (count_eff != '0), state_reg == tcs_pkg::ST_SCAN, "query with triangles did not start a scan")

endmodule

FILE: rtl/triangle_centroid_height_search.sv
`timescale 1ns / 1ps
// =============================================================================
// Triangle centroid height search
// Load items produce no result; further loads are accepted while the block is idle.
// A query over N > 0 triangles passes N issues, seven pipe stages, a drain check
// and the output load before its result is valid; N = 0 needs only the output load.
// One query is in flight at a time, so no item is accepted until its result is loaded.
// Reset (synchronous, active low) clears control and triangle_count, not stores.
// =============================================================================
//
// Vertex and triangle load transactions write the stores directly. A query
// transaction scans triangles 0 .. triangle_count-1 (at most the store depth)
// in order. For each triangle the centroid x and z are formed as the sum of
// the three corners divided by three, rounded toward zero; the triangle is
// taken when both axis distances to the query point are strictly below the
// best distances held so far. The result carries the mean height of the last
// triangle taken, or zero with the found flag cleared.
//
// The controller holds the state machine and the scan index; the datapath
// holds the stores, the arithmetic pipeline and the output register, so a
// finished result may wait on the master side while loads keep flowing in.
// Loads and queries are refused while a query scans or waits to hand off.
// Stores are not cleared by reset; a query must only reach entries that have
// been written.

module triangle_centroid_height_search (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata, low to high: slot[12:0], coord_x[36:13], coord_h[60:37],
    // coord_z[84:61], corner_a[96:85], corner_b[108:97], corner_c[120:109].
    input  logic [tcs_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: kind[1:0].
    input  logic [tcs_pkg::KIND_W-1:0]    s_tuser,

    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: height[23:0].
    output logic [tcs_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: found.
    output logic                          m_tuser,

    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcs_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcs_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [tcs_pkg::COUNT_W-1:0] count_reg;
    logic                        reg_sel;
    tcs_pkg::cmd_t               cmd;
    tcs_pkg::status_t            status;

    // Registers sit on 4-byte boundaries; bit 2 selects the register index.
    assign reg_sel = (paddr[2] == tcs_pkg::REG_TRIANGLE_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? tcs_pkg::PDATA_W'(count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            count_reg <= pwdata[tcs_pkg::COUNT_W-1:0];
        end
    end

    tcs_control u_control (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .kind           (s_tuser),
        .triangle_count (count_reg),
        .cmd            (cmd),
        .status         (status)
    );

    tcs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
